@@ hw/rtl/pfcb_pkg.sv @@
// Shared types and codes for the pretrigger frame capture buffer.
package pfcb_pkg;

  localparam int CfgDataBits = 32;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_SEEK   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_REC  = 2'd1,
    MODE_STOP = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_TOSSED    = 3'd1,
    STS_DURATION  = 3'd2,
    STS_FULL      = 3'd3,
    STS_SEEK_OOR  = 3'd4,
    STS_READ_END  = 3'd5
  } status_e;

  localparam logic REG_START_SHIFT = 1'b0;
  localparam logic REG_DURATION    = 1'b1;

endpackage

@@ hw/rtl/pfcb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pfcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pretrigger_frame_capture_buffer_unit.sv @@
// Pretrigger frame capture buffer: frame queue with waiting, recording and stopped modes.
//
// Input channel (in_valid_i / in_stall_o) carries one request per transaction:
// append, seek, read next or clear. Output channel (out_valid_o / out_stall_i)
// returns exactly one result per request. Configuration registers start_shift
// (index 0) and duration_limit (index 1) are written through cfg_we_i; the user
// must write them only while idle; the block itself does not enforce this.
// Requests run one at a time through a small sequencer around two RAMs (handle
// and timestamp) that share one read port address. Steps per request:
//   seek, clear, tossed or refused append: take, execute, emit; read next adds a handle read step when an entry remains
//   append: take, execute, write, front read, front check (front read and check repeat per frame trimmed), emit
// The trim loop is bounded by the one timestamp RAM read per front entry.
// A finished result sits in the output register; the next request is taken
// while it waits, and the sequencer holds in its last step only if a second
// result is ready before the first is taken. A stalled result holds steady.
// Reset empties the queue, clears both registers and sets recording mode;
// no RAM clearing pass is needed since only held entries are read.
module pretrigger_frame_capture_buffer_unit
  import pfcb_pkg::*;
#(
  parameter int DEPTH       = 256,
  parameter int HANDLE_BITS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             req_type_i,
  input  logic [HANDLE_BITS-1:0] frame_handle_i,
  input  logic [TIME_BITS-1:0]   frame_time_i,
  input  logic [7:0]             seek_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic [15:0]            read_handle_o,
  output logic                   at_end_o,
  output logic [8:0]             entry_count_o,
  output logic [7:0]             discarded_count_o,
  output logic [1:0]             recording_mode_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = TIME_BITS + 34;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WRITE,
    ST_FRONT_RD,
    ST_FRONT_CHK,
    ST_HREAD,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [AW-1:0]          front_q;
  logic [CW-1:0]          total_q;
  logic [CW-1:0]          rp_q;
  mode_e                  mode_q;
  logic [TIME_BITS-1:0]   ft_q;
  logic                   ftv_q;
  logic [31:0]            shift_q;
  logic [31:0]            dur_q;
  req_e                   req_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [TIME_BITS-1:0]   time_q;
  logic [7:0]             seek_q;
  status_e                status_q;
  logic [15:0]            rdh_q;
  logic [7:0]             drop_q;

  logic                   out_valid_q;
  logic [2:0]             out_status_q;
  logic [15:0]            out_rdh_q;
  logic                   out_at_end_q;
  logic [8:0]             out_count_q;
  logic [7:0]             out_drop_q;
  logic [1:0]             out_mode_q;

  // RAM ports
  logic                   ram_we;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [HANDLE_BITS-1:0] hnd_rdata;
  logic [TIME_BITS-1:0]   time_rdata;

  // Slot address and pointer helpers
  logic [CW-1:0]          slot_off;
  logic [CW:0]            slot_sum;
  logic [CW:0]            slot_wrap;
  logic [AW-1:0]          slot_addr;
  logic [AW-1:0]          front_inc;
  logic [CW-1:0]          rp_dec;
  logic [7:0]             drop_inc;

  // Arithmetic
  logic [TIME_BITS-1:0]   ft_d;
  logic signed [SW-1:0]   t_s;
  logic signed [SW-1:0]   ft_s;
  logic signed [SW-1:0]   sh_s;
  logic signed [SW-1:0]   fr_s;
  logic signed [SW-1:0]   diff_s;
  logic signed [SW-1:0]   lim_s;
  logic                   shift_pos;
  logic                   shift_neg;
  logic [TIME_BITS-1:0]   span;
  logic                   dur_hit;
  logic                   trim_hit;
  logic [CW+7:0]          seek_x;
  logic [CW+7:0]          total_x;
  logic [HANDLE_BITS+15:0] rdh_x;
  logic [CW+8:0]          count_x;
  logic                   out_free;

  assign slot_off  = (state_q == ST_WRITE) ? total_q : rp_q;
  assign slot_sum  = {{(CW + 1 - AW){1'b0}}, front_q} + {1'b0, slot_off};
  assign slot_wrap = (slot_sum >= (CW + 1)'(DEPTH)) ? slot_sum - (CW + 1)'(DEPTH) : slot_sum;
  assign slot_addr = slot_wrap[AW-1:0];
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign rp_dec    = (rp_q != '0) ? rp_q - 1'b1 : rp_q;
  assign drop_inc  = (drop_q == 8'hFF) ? drop_q : drop_q + 8'd1;

  assign ft_d      = ftv_q ? ft_q : time_q;
  assign t_s       = $signed({34'b0, time_q});
  assign ft_s      = $signed({34'b0, ft_d});
  assign fr_s      = $signed({34'b0, time_rdata});
  assign sh_s      = $signed({{(TIME_BITS + 2){shift_q[31]}}, shift_q});
  assign diff_s    = t_s - ft_s;
  assign lim_s     = t_s + sh_s;
  assign shift_pos = !shift_q[31] && (shift_q != '0);
  assign shift_neg = shift_q[31];
  assign span      = time_q - time_rdata;
  assign dur_hit   = (dur_q != '0) && ({32'b0, span} >= {{TIME_BITS{1'b0}}, dur_q});
  assign trim_hit  = shift_neg && (mode_q == MODE_WAIT) && (total_q > CW'(1)) && (fr_s < lim_s);
  assign seek_x    = {{CW{1'b0}}, seek_q};
  assign total_x   = {8'b0, total_q};
  assign rdh_x     = {16'b0, hnd_rdata};
  assign count_x   = {9'b0, total_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  assign ram_we    = (state_q == ST_WRITE);
  assign ram_re    = (state_q == ST_FRONT_RD) ||
                     ((state_q == ST_EXEC) && (req_q == REQ_READ));
  assign ram_raddr = (state_q == ST_FRONT_RD) ? front_q : slot_addr;

  pfcb_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_addr),
    .wdata_i (hnd_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (hnd_rdata)
  );

  pfcb_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (DEPTH)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_addr),
    .wdata_i (time_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (time_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      front_q      <= '0;
      total_q      <= '0;
      rp_q         <= '0;
      mode_q       <= MODE_REC;
      ft_q         <= '0;
      ftv_q        <= 1'b0;
      shift_q      <= '0;
      dur_q        <= '0;
      req_q        <= REQ_APPEND;
      status_q     <= STS_OK;
      rdh_q        <= '0;
      drop_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_rdh_q    <= '0;
      out_at_end_q <= 1'b0;
      out_count_q  <= '0;
      out_drop_q   <= '0;
      out_mode_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_START_SHIFT) begin
          shift_q <= cfg_data_i;
          if (!ftv_q) begin
            mode_q <= (cfg_data_i == '0) ? MODE_REC : MODE_WAIT;
          end
        end else begin
          dur_q <= cfg_data_i;
        end
      end

      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q    <= req_e'(req_type_i);
            hnd_q    <= frame_handle_i;
            time_q   <= frame_time_i;
            seek_q   <= seek_index_i;
            status_q <= STS_OK;
            rdh_q    <= '0;
            drop_q   <= '0;
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (req_q)
            REQ_APPEND: begin
              if (mode_q == MODE_STOP) begin
                status_q <= STS_TOSSED;
                state_q  <= ST_EMIT;
              end else begin
                ft_q  <= ft_d;
                ftv_q <= 1'b1;
                if (shift_pos && (mode_q == MODE_WAIT)) begin
                  if (diff_s < sh_s) begin
                    if (total_q == CW'(1)) begin
                      front_q <= front_inc;
                      total_q <= '0;
                      rp_q    <= rp_dec;
                      drop_q  <= 8'd1;
                    end
                  end else begin
                    mode_q <= MODE_REC;
                  end
                end
                if (total_q >= CW'(DEPTH)) begin
                  status_q <= STS_FULL;
                  state_q  <= ST_EMIT;
                end else begin
                  state_q <= ST_WRITE;
                end
              end
            end
            REQ_SEEK: begin
              if (seek_x >= total_x) begin
                status_q <= STS_SEEK_OOR;
              end else begin
                rp_q <= seek_x[CW-1:0];
              end
              state_q <= ST_EMIT;
            end
            REQ_READ: begin
              if (rp_q < total_q) begin
                state_q <= ST_HREAD;
              end else begin
                status_q <= STS_READ_END;
                state_q  <= ST_EMIT;
              end
            end
            REQ_CLEAR: begin
              front_q <= '0;
              total_q <= '0;
              rp_q    <= '0;
              ft_q    <= '0;
              ftv_q   <= 1'b0;
              mode_q  <= (shift_q == '0) ? MODE_REC : MODE_WAIT;
              state_q <= ST_EMIT;
            end
            default: begin
              state_q <= ST_EMIT;
            end
          endcase
        end
        ST_WRITE: begin
          total_q <= total_q + 1'b1;
          state_q <= ST_FRONT_RD;
        end
        ST_FRONT_RD: begin
          state_q <= ST_FRONT_CHK;
        end
        ST_FRONT_CHK: begin
          if (trim_hit) begin
            front_q <= front_inc;
            total_q <= total_q - 1'b1;
            rp_q    <= rp_dec;
            drop_q  <= drop_inc;
            state_q <= ST_FRONT_RD;
          end else begin
            if (dur_hit) begin
              mode_q   <= MODE_STOP;
              status_q <= STS_DURATION;
            end
            state_q <= ST_EMIT;
          end
        end
        ST_HREAD: begin
          rdh_q   <= rdh_x[15:0];
          rp_q    <= rp_q + 1'b1;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_rdh_q    <= rdh_q;
            out_at_end_q <= (rp_q >= total_q);
            out_count_q  <= count_x[8:0];
            out_drop_q   <= drop_q;
            out_mode_q   <= mode_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign read_handle_o     = out_rdh_q;
  assign at_end_o          = out_at_end_q;
  assign entry_count_o     = out_count_q;
  assign discarded_count_o = out_drop_q;
  assign recording_mode_o  = out_mode_q;

endmodule
